FILE: hdl/sbfe_pkg.sv
// Package for the servo bus frame engine: item structs, job queue entry,
// function and job codes, frame constants. No dependencies.
`default_nettype none

package sbfe_pkg;

  // response layout
  localparam int RESPONSE_LENGTH = 12;
  localparam logic [3:0] RX_LAST_IDX = 4'(RESPONSE_LENGTH - 1);

  // job queue depth and pointer width
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

  // frame bytes
  localparam logic [7:0] HDR_A     = 8'h12;
  localparam logic [7:0] HDR_B     = 8'h4C;
  localparam logic [7:0] CMD_POS   = 8'h0D;
  localparam logic [7:0] CMD_READ  = 8'h10;
  localparam logic [7:0] CMD_SYNC  = 8'h19;
  localparam logic [7:0] LEN_POS   = 8'd11;
  localparam logic [7:0] LEN_READ  = 8'h01;
  localparam logic [7:0] LEN_SYNC  = 8'd36;
  localparam logic [7:0] SYNC_CNT  = 8'h03;
  localparam logic [7:0] RSP_A     = 8'h05;
  localparam logic [7:0] RSP_B     = 8'h1C;

  // last byte index of each frame
  localparam logic [5:0] POS_LAST  = 6'd15;
  localparam logic [5:0] READ_LAST = 6'd5;
  localparam logic [5:0] SYNC_LAST = 6'd40;

  // input function codes
  typedef enum logic [1:0] {
    FUNC_POS  = 2'd0,
    FUNC_READ = 2'd1,
    FUNC_SYNC = 2'd2,
    FUNC_RX   = 2'd3
  } func_e_t;

  // queued job codes
  typedef enum logic [1:0] {
    JOB_POS    = 2'd0,
    JOB_READ   = 2'd1,
    JOB_SYNC   = 2'd2,
    JOB_REPORT = 2'd3
  } job_code_t;

  typedef struct packed {
    func_e_t            func;
    logic [7:0]         dest_id;
    logic signed [31:0] target_tenths;
    logic signed [31:0] second_tenths;
    logic signed [31:0] third_tenths;
    logic [31:0]        move_time_ms;
    logic [15:0]        drive_power;
    logic [7:0]         rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         tx_byte;
    logic               last;
    logic signed [31:0] angle_tenths;
    logic signed [15:0] turns;
    logic               ok;
  } out_item_t;

  // a report reuses ang0 for the angle and power for the turn count
  typedef struct packed {
    job_code_t   code;
    logic [7:0]  id;
    logic [31:0] ang0;
    logic [31:0] ang1;
    logic [31:0] ang2;
    logic [31:0] move_ms;
    logic [15:0] power;
    logic        rpt_ok;
  } job_t;

endpackage

`default_nettype wire

FILE: hdl/sbfe_queue.sv
// Two-entry job queue between the front classifier and the back serializer.
// Depends on sbfe_pkg.
`default_nettype none

module sbfe_queue
  import sbfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  job_t                slots [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_ptr;
  logic [QUEUE_PW-1:0] rd_ptr;
  logic [QUEUE_PW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == (QUEUE_PW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sbfe_front.sv
// Front end: accepts items, runs the response receiver and queues frame
// and report jobs. Depends on sbfe_pkg.
`default_nettype none

module sbfe_front
  import sbfe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cmd_valid,
  output logic          cmd_ready,
  input  wire in_item_t cmd,
  output logic          push,
  output job_t          push_job,
  input  wire logic     q_full
);

  logic        rx_armed;
  logic [3:0]  rx_index;
  logic [7:0]  rx_sum;
  logic        rx_header_good;
  logic [31:0] rx_position;
  logic [15:0] rx_turn_count;

  logic        accept;
  logic        rx_end;
  logic        good;
  logic [1:0]  pos_lane;
  logic        turn_lane;

  assign cmd_ready = !q_full;
  assign accept    = cmd_valid && cmd_ready;
  assign rx_end    = rx_armed && (rx_index >= RX_LAST_IDX);
  assign good      = rx_header_good && (cmd.rx_byte == rx_sum);
  assign pos_lane  = 2'(rx_index - 4'd5);
  assign turn_lane = 1'(rx_index - 4'd9);

  // job classification
  always_comb begin
    push_job         = '0;
    push_job.id      = cmd.dest_id;
    push_job.ang0    = cmd.target_tenths;
    push_job.ang1    = cmd.second_tenths;
    push_job.ang2    = cmd.third_tenths;
    push_job.move_ms = cmd.move_time_ms;
    push_job.power   = cmd.drive_power;
    push             = 1'b0;
    unique case (cmd.func)
      FUNC_POS: begin
        push_job.code = JOB_POS;
        push          = accept;
      end
      FUNC_READ: begin
        push_job.code = JOB_READ;
        push          = accept;
      end
      FUNC_SYNC: begin
        push_job.code = JOB_SYNC;
        push          = accept;
      end
      default: begin
        push_job.code   = JOB_REPORT;
        push_job.ang0   = good ? rx_position : '0;
        push_job.power  = good ? rx_turn_count : '0;
        push_job.rpt_ok = good;
        push            = accept && rx_end;
      end
    endcase
  end

  // response receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_armed       <= 1'b0;
      rx_index       <= '0;
      rx_sum         <= '0;
      rx_header_good <= 1'b1;
      rx_position    <= '0;
      rx_turn_count  <= '0;
    end else if (accept) begin
      if (cmd.func == FUNC_READ || (cmd.func == FUNC_RX && rx_end)) begin
        rx_armed       <= (cmd.func == FUNC_READ);
        rx_index       <= '0;
        rx_sum         <= '0;
        rx_header_good <= 1'b1;
        rx_position    <= '0;
        rx_turn_count  <= '0;
      end else if (cmd.func == FUNC_RX && rx_armed) begin
        if ((rx_index == 4'd0 && cmd.rx_byte != RSP_A) ||
            (rx_index == 4'd1 && cmd.rx_byte != RSP_B)) begin
          rx_header_good <= 1'b0;
        end
        if (rx_index >= 4'd5 && rx_index <= 4'd8) begin
          rx_position[pos_lane*8 +: 8] <= rx_position[pos_lane*8 +: 8] | cmd.rx_byte;
        end
        if (rx_index >= 4'd9 && rx_index <= 4'd10) begin
          rx_turn_count[turn_lane*8 +: 8] <= rx_turn_count[turn_lane*8 +: 8] | cmd.rx_byte;
        end
        rx_sum   <= rx_sum + cmd.rx_byte;
        rx_index <= rx_index + 4'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sbfe_back.sv
// Back end: turns queued jobs into transmit bytes with a running checksum,
// or into one feedback report, through an output register. Depends on sbfe_pkg.
`default_nettype none

module sbfe_back
  import sbfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_valid,
  input  wire job_t head_job,
  output logic      pop,
  output logic      res_valid,
  input  wire logic res_ready,
  output out_item_t res
);

  logic [5:0] idx;
  logic [7:0] sum;
  logic       load;
  logic       is_last;
  logic [5:0] last_idx;
  logic [7:0] body_byte;
  logic [7:0] cur_byte;
  logic [5:0] rel;
  logic [5:0] off;
  logic [7:0] sync_id;
  logic [31:0] sync_ang;

  // pick byte lane of a word
  function automatic logic [7:0] lane8(input logic [31:0] v, input logic [1:0] sel);
    lane8 = v[sel*8 +: 8];
  endfunction

  // last index per frame type
  always_comb begin
    unique case (head_job.code)
      JOB_POS:  last_idx = POS_LAST;
      JOB_READ: last_idx = READ_LAST;
      JOB_SYNC: last_idx = SYNC_LAST;
      default:  last_idx = '0;
    endcase
  end

  // sync servo slot: 11 bytes each after the 7-byte preamble
  always_comb begin
    rel = idx - 6'd7;
    if (rel >= 6'd22) begin
      sync_id  = 8'd2;
      sync_ang = head_job.ang2;
      off      = rel - 6'd22;
    end else if (rel >= 6'd11) begin
      sync_id  = 8'd1;
      sync_ang = head_job.ang1;
      off      = rel - 6'd11;
    end else begin
      sync_id  = 8'd0;
      sync_ang = head_job.ang0;
      off      = rel;
    end
  end

  // frame body byte
  always_comb begin
    body_byte = '0;
    unique case (head_job.code)
      JOB_POS, JOB_READ: begin
        if (idx == 6'd0)       body_byte = HDR_A;
        else if (idx == 6'd1)  body_byte = HDR_B;
        else if (idx == 6'd2)  body_byte = (head_job.code == JOB_POS) ? CMD_POS : CMD_READ;
        else if (idx == 6'd3)  body_byte = (head_job.code == JOB_POS) ? LEN_POS : LEN_READ;
        else if (idx == 6'd4)  body_byte = head_job.id;
        else if (idx <= 6'd8)  body_byte = lane8(head_job.ang0, 2'(idx - 6'd5));
        else if (idx <= 6'd12) body_byte = lane8(head_job.move_ms, 2'(idx - 6'd9));
        else                   body_byte = lane8({16'd0, head_job.power}, 2'(idx - 6'd13));
      end
      JOB_SYNC: begin
        if (idx == 6'd0)      body_byte = HDR_A;
        else if (idx == 6'd1) body_byte = HDR_B;
        else if (idx == 6'd2) body_byte = CMD_SYNC;
        else if (idx == 6'd3) body_byte = LEN_SYNC;
        else if (idx == 6'd4) body_byte = CMD_POS;
        else if (idx == 6'd5) body_byte = LEN_POS;
        else if (idx == 6'd6) body_byte = SYNC_CNT;
        else if (off == 6'd0) body_byte = sync_id;
        else if (off <= 6'd4) body_byte = lane8(sync_ang, 2'(off - 6'd1));
        else if (off <= 6'd8) body_byte = lane8(head_job.move_ms, 2'(off - 6'd5));
        else                  body_byte = lane8({16'd0, head_job.power}, 2'(off - 6'd9));
      end
      default: body_byte = '0;
    endcase
  end

  assign is_last  = (idx == last_idx);
  assign cur_byte = is_last ? sum : body_byte;
  assign load     = head_valid && (!res_valid || res_ready);
  assign pop      = load && is_last;

  // byte counter and running checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      sum <= '0;
    end else if (load) begin
      if (is_last) begin
        idx <= '0;
        sum <= '0;
      end else begin
        idx <= idx + 6'd1;
        sum <= sum + cur_byte;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head_job.code == JOB_REPORT) begin
        res.kind         <= 1'b1;
        res.tx_byte      <= '0;
        res.last         <= 1'b1;
        res.angle_tenths <= head_job.ang0;
        res.turns        <= head_job.power;
        res.ok           <= head_job.rpt_ok;
      end else begin
        res.kind         <= 1'b0;
        res.tx_byte      <= cur_byte;
        res.last         <= is_last;
        res.angle_tenths <= '0;
        res.turns        <= '0;
        res.ok           <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/servo_bus_frame_engine_unit.sv
// Top level of the servo bus frame engine: front end, job queue, back end.
// Depends on sbfe_pkg, sbfe_front, sbfe_queue, sbfe_back.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one item per cycle: a position
//   command, a read request, a sync command or one received bus byte.
//   res channel (res_valid/res_ready/res) gives transmit bytes and reports.
//   A position command yields 16 bytes, a read request 6, a sync command 41,
//   one per cycle from the back-end byte counter; last marks each frame end.
//   The final byte of a response yields one feedback report; other received
//   bytes yield nothing and are taken one per cycle while the queue has room.
//   With the back end idle, an accepted item passes through the job queue and
//   then the output register before res_valid rises.
//   Throughput: one result per cycle from the back-end serializer while res_ready
//   is high; cmd stalls only while the two-entry job queue is full.
//   A read request arms the receiver at once; a later request restarts it.
//   Reset clears the receiver (not armed), the queue and res_valid.
//   If the receiver holds res_ready low, the output register holds its item,
//   the serializer stops and, once the queue fills, cmd_ready drops.
`default_nettype none

module servo_bus_frame_engine_unit
  import sbfe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_ready,
  input  wire in_item_t  cmd,
  output logic           res_valid,
  input  wire logic      res_ready,
  output out_item_t      res
);

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  logic head_valid;
  job_t head_job;

  // classify and run the receiver
  sbfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  // job queue
  sbfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // serialize frames and reports
  sbfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

`default_nettype wire
